[rtl/trd_pkg.sv]
package trd_pkg;

  localparam int PADDR_W     = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int LAST_W      = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [7:0] TAG_BYTES [4] = '{8'h5C, 8'hD6, 8'hC1, 8'hD4};

  localparam logic [7:0] EBC_TO_ASC [256] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h1A, 8'h09, 8'h1A, 8'h7F,
    8'h1A, 8'h1A, 8'h1A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h1A, 8'h1A, 8'h08, 8'h1A,
    8'h18, 8'h19, 8'h1A, 8'h1A, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h0A, 8'h17, 8'h1B,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h05, 8'h06, 8'h07,
    8'h1A, 8'h1A, 8'h16, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h04,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h14, 8'h15, 8'h1A, 8'h1A,
    8'h20, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h5B, 8'h2E, 8'h3C, 8'h28, 8'h2B, 8'h21,
    8'h26, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h5D, 8'h24, 8'h2A, 8'h29, 8'h3B, 8'h5E,
    8'h2D, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h7C, 8'h2C, 8'h25, 8'h5F, 8'h3E, 8'h3F,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h60, 8'h3A, 8'h23, 8'h40, 8'h27, 8'h3D, 8'h22,
    8'h1A, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
    8'h71, 8'h72, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h7E, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h7B, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h7D, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
    8'h51, 8'h52, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h5C, 8'h1A, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A
  };

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_COLL    = 3'd1,
    KIND_OBJ     = 3'd2,
    KIND_START   = 3'd3,
    KIND_SYNC    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CMD_PAYLOAD,
    CMD_RUN,
    CMD_START,
    CMD_SYNC
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [7:0]         data;
    logic               bank;
    logic [LAST_W-1:0]  last;
    logic [31:0]        bsize;
    logic [31:0]        offset;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [LAST_W-1:0]  k;
    logic [7:0]         data;
  } name_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } run_rel_t;

endpackage

[rtl/trd_if.sv]
interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;

  modport source (output valid, output tape_byte, input ready);
  modport sink (input valid, input tape_byte, output ready);
endinterface

interface trd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] block_size;
  logic [31:0] header_offset;
  logic        last_of_run;

  modport source (output valid, output kind, output data_byte, output block_size,
                  output header_offset, output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input block_size,
                input header_offset, input last_of_run, output ready);
endinterface

[rtl/tape_record_deframer.sv]
// Splits a tape image, one byte per request on in_ch, into records of a
// fixed-size header and a raw payload, and emits name characters, a record
// start (or sync error) and payload bytes on out_ch. A byte is taken every
// cycle while the four-entry request queue has room; each name run of L
// trimmed characters is played out of the name buffer by the back end,
// and the input stalls only when the queue fills or when the next
// record's name would overwrite a bank whose run is still being read.
// After a sync error every further byte is taken and dropped until reset.
// stream_length (byte address 0) must be written before the image is fed.
module tape_record_deframer #(
  parameter int NAME_BYTES   = 44,
  parameter int HEADER_BYTES = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  trd_in_if.sink                         in_ch,
  trd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trd_pkg::PADDR_W-1:0]    paddr,
  input  logic [trd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [trd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import trd_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_STREAM_LENGTH = '0;

  logic [31:0] stream_length_r;
  logic        push, full, pop, empty;
  cmd_t        push_cmd, head;
  name_wr_t    name_wr;
  run_rel_t    run_rel;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STREAM_LENGTH) ? stream_length_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_length_r <= '0;
    end else if (psel && penable && pwrite && (paddr == ADDR_STREAM_LENGTH)) begin
      stream_length_r <= pwdata;
    end
  end

  trd_front #(
    .NAME_BYTES   (NAME_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .stream_length (stream_length_r),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.tape_byte),
    .push          (push),
    .push_cmd      (push_cmd),
    .full          (full),
    .name_wr       (name_wr),
    .run_rel       (run_rel)
  );

  trd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  trd_back #(
    .NAME_BYTES (NAME_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .head              (head),
    .pop               (pop),
    .name_wr           (name_wr),
    .run_rel           (run_rel),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_data_byte     (out_ch.data_byte),
    .out_block_size    (out_ch.block_size),
    .out_header_offset (out_ch.header_offset),
    .out_last_of_run   (out_ch.last_of_run)
  );

endmodule

[rtl/trd_front.sv]
module trd_front #(
  parameter int NAME_BYTES   = 44,
  parameter int HEADER_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       stream_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output trd_pkg::cmd_t     push_cmd,
  input  logic              full,
  output trd_pkg::name_wr_t name_wr,
  input  trd_pkg::run_rel_t run_rel
);
  import trd_pkg::*;

  localparam int HDR_LEN = (HEADER_BYTES >= 2 * NAME_BYTES + 16) ?
                           HEADER_BYTES : 2 * NAME_BYTES + 16;
  localparam int SIZE_AT = 2 * NAME_BYTES + 8;
  localparam int TAG_AT  = 2 * NAME_BYTES + 12;
  localparam int IW      = $clog2(HDR_LEN);
  localparam int KW      = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_HALT} phase_t;

  phase_t          phase_r, phase_nxt;
  logic [IW-1:0]   hidx_r, hidx_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [31:0]     rec_r, rec_nxt;
  logic [KW-1:0]   lastns_r, lastns_nxt;
  logic [31:0]     size_r, size_nxt;
  logic            tag_ok_r, tag_ok_nxt;
  logic [31:0]     left_r, left_nxt;
  logic [1:0]      busy_r, busy_nxt;

  logic            room, in_hdr, is_name, bank, blocked, acc;
  logic            is_size, is_tag, tag_last, hdr_last, tag_ok_cur;
  logic [IW-1:0]   idx, kfull;
  logic [KW-1:0]   k, lastns_new;
  logic [7:0]      char_c;
  logic [31:0]     offset_eff;

  assign room = {1'b0, stream_length} > ({1'b0, pos_r} + 33'(HEADER_BYTES));
  assign in_hdr = (phase_r == PH_HEADER) || ((phase_r == PH_IDLE) && room);
  assign idx = (phase_r == PH_HEADER) ? hidx_r : '0;
  assign is_name = idx < IW'(2 * NAME_BYTES);
  assign bank = idx >= IW'(NAME_BYTES);
  assign kfull = bank ? idx - IW'(NAME_BYTES) : idx;
  assign k = kfull[KW-1:0];
  assign char_c = EBC_TO_ASC[in_byte];
  assign lastns_new = ((k == '0) || (char_c != SPACE_CHAR)) ? k : lastns_r;
  assign is_size = (idx >= IW'(SIZE_AT)) && (idx < IW'(SIZE_AT + 4));
  assign is_tag = (idx >= IW'(TAG_AT)) && (idx < IW'(TAG_AT + 4));
  assign tag_last = idx == IW'(TAG_AT + 3);
  assign hdr_last = idx == IW'(HDR_LEN - 1);
  assign tag_ok_cur = tag_ok_r && (in_byte == TAG_BYTES[2'(idx - IW'(TAG_AT))]);
  assign offset_eff = (phase_r == PH_IDLE) ? pos_r : rec_r;

  assign blocked = in_hdr && is_name && busy_r[bank];
  assign in_ready = !full && !blocked;
  assign acc = in_valid && in_ready;

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    pos_nxt    = pos_r;
    rec_nxt    = rec_r;
    lastns_nxt = lastns_r;
    size_nxt   = size_r;
    tag_ok_nxt = tag_ok_r;
    left_nxt   = left_r;
    busy_nxt   = busy_r;
    push       = 1'b0;
    push_cmd   = '{op: CMD_PAYLOAD, data: in_byte, bank: bank,
                   last: LAST_W'(lastns_new), bsize: size_r, offset: offset_eff};
    name_wr    = '{en: 1'b0, bank: bank, k: LAST_W'(k), data: char_c};

    if (run_rel.valid) begin
      busy_nxt[run_rel.bank] = 1'b0;
    end

    if (acc) begin
      pos_nxt = pos_r + 32'd1;
      if (in_hdr) begin
        phase_nxt = PH_HEADER;
        rec_nxt   = offset_eff;
        hidx_nxt  = idx + 1'b1;
        if (idx == '0) begin
          size_nxt   = '0;
          tag_ok_nxt = 1'b1;
        end
        if (is_name) begin
          name_wr.en = 1'b1;
          lastns_nxt = lastns_new;
          if (k == KW'(NAME_BYTES - 1)) begin
            push           = 1'b1;
            push_cmd.op    = CMD_RUN;
            busy_nxt[bank] = 1'b1;
          end
        end else if (is_size) begin
          size_nxt = {size_r[23:0], in_byte};
        end else if (is_tag) begin
          tag_ok_nxt = tag_ok_cur;
          if (tag_last) begin
            push        = 1'b1;
            push_cmd.op = tag_ok_cur ? CMD_START : CMD_SYNC;
          end
        end
        priority if (tag_last && !tag_ok_cur) begin
          phase_nxt = PH_HALT;
          hidx_nxt  = hidx_r;
        end else if (hdr_last) begin
          hidx_nxt  = '0;
          left_nxt  = size_r;
          phase_nxt = (size_r != '0) ? PH_PAYLOAD : PH_IDLE;
        end else begin
        end
      end else if (phase_r == PH_PAYLOAD) begin
        push     = 1'b1;
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hidx_r   <= '0;
      pos_r    <= '0;
      rec_r    <= '0;
      lastns_r <= '0;
      size_r   <= '0;
      tag_ok_r <= 1'b1;
      left_r   <= '0;
      busy_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      pos_r    <= pos_nxt;
      rec_r    <= rec_nxt;
      lastns_r <= lastns_nxt;
      size_r   <= size_nxt;
      tag_ok_r <= tag_ok_nxt;
      left_r   <= left_nxt;
      busy_r   <= busy_nxt;
    end
  end

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |-> !push)
    else $error("request queued after sync error");

  a_no_busy_write: assert property (@(posedge clk) disable iff (!rst_n)
    name_wr.en |-> !busy_r[name_wr.bank])
    else $error("name bank overwritten while its run is pending");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_rel.valid |-> busy_r[run_rel.bank])
    else $error("run released for an idle bank");

endmodule

[rtl/trd_fifo.sv]
module trd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output trd_pkg::cmd_t head,
  output logic          empty
);
  import trd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  assign full  = count_r == CW'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue underflow");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count out of step");

endmodule

[rtl/trd_back.sv]
module trd_back #(
  parameter int NAME_BYTES = 44
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  trd_pkg::cmd_t     head,
  output logic              pop,
  input  trd_pkg::name_wr_t name_wr,
  output trd_pkg::run_rel_t run_rel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_data_byte,
  output logic [31:0]       out_block_size,
  output logic [31:0]       out_header_offset,
  output logic              out_last_of_run
);
  import trd_pkg::*;

  localparam int KW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  logic [7:0]    name_mem [2**(KW+1)];
  logic [7:0]    rdata_r;

  bstate_t       state_r, state_nxt;
  logic          run_bank_r, run_bank_nxt;
  logic [KW-1:0] run_idx_r, run_idx_nxt;
  logic [KW-1:0] run_last_r, run_last_nxt;
  logic [31:0]   run_off_r, run_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic [31:0]   out_bsize_r, out_bsize_nxt;
  logic [31:0]   out_off_r, out_off_nxt;
  logic          out_last_r, out_last_nxt;
  logic          slot_free, run_end;

  assign slot_free = !out_valid_r || out_ready;
  assign run_end   = run_idx_r == run_last_r;

  always_comb begin
    state_nxt     = state_r;
    run_bank_nxt  = run_bank_r;
    run_idx_nxt   = run_idx_r;
    run_last_nxt  = run_last_r;
    run_off_nxt   = run_off_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_bsize_nxt = out_bsize_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    run_rel       = '{valid: 1'b0, bank: run_bank_r};

    unique case (state_r)
      B_IDLE: begin
        if (!empty && slot_free) begin
          pop = 1'b1;
          if (head.op == CMD_RUN) begin
            state_nxt    = B_RUN;
            run_bank_nxt = head.bank;
            run_idx_nxt  = '0;
            run_last_nxt = head.last[KW-1:0];
            run_off_nxt  = head.offset;
          end else begin
            out_valid_nxt = 1'b1;
            out_off_nxt   = head.offset;
            out_last_nxt  = 1'b0;
            unique case (head.op)
              CMD_PAYLOAD: begin
                out_kind_nxt  = KIND_PAYLOAD;
                out_data_nxt  = head.data;
                out_bsize_nxt = '0;
              end
              CMD_START: begin
                out_kind_nxt  = KIND_START;
                out_data_nxt  = '0;
                out_bsize_nxt = head.bsize;
              end
              default: begin
                out_kind_nxt  = KIND_SYNC;
                out_data_nxt  = '0;
                out_bsize_nxt = head.bsize;
              end
            endcase
          end
        end
      end
      B_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = run_bank_r ? KIND_OBJ : KIND_COLL;
          out_data_nxt  = rdata_r;
          out_bsize_nxt = '0;
          out_off_nxt   = run_off_r;
          out_last_nxt  = run_end;
          if (run_end) begin
            state_nxt     = B_IDLE;
            run_rel.valid = 1'b1;
          end else begin
            run_idx_nxt = run_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (name_wr.en) begin
      name_mem[{name_wr.bank, name_wr.k[KW-1:0]}] <= name_wr.data;
    end
    rdata_r <= name_mem[{run_bank_nxt, run_idx_nxt}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    run_bank_r  <= run_bank_nxt;
    run_idx_r   <= run_idx_nxt;
    run_last_r  <= run_last_nxt;
    run_off_r   <= run_off_nxt;
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_bsize_r <= out_bsize_nxt;
    out_off_r   <= out_off_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data_byte     = out_data_r;
  assign out_block_size    = out_bsize_r;
  assign out_header_offset = out_off_r;
  assign out_last_of_run   = out_last_r;

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |-> (run_idx_r <= run_last_r))
    else $error("name run read past its end");

  a_last_only_names: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_COLL || out_kind_r == KIND_OBJ))
    else $error("run end flag on a non-name result");

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trd_pkg::*;

  localparam int NAME_LEN      = 44;
  localparam int HDR_LEN       = 128;
  localparam int SIZE_AT       = 2 * NAME_LEN + 8;
  localparam int TAG_AT        = 2 * NAME_LEN + 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 480;

  localparam logic [PADDR_W-1:0] ADDR_STREAM_LENGTH = '0;

  localparam logic [7:0] BLANK       = 8'h20;
  localparam logic [7:0] EBCDIC_BLANK = 8'h40;
  localparam logic [7:0] SYNC_TAG [4] = '{8'h5C, 8'hD6, 8'hC1, 8'hD4};

  localparam logic [7:0] ASCII_OF_EBCDIC [256] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h1A, 8'h09, 8'h1A, 8'h7F,
    8'h1A, 8'h1A, 8'h1A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h1A, 8'h1A, 8'h08, 8'h1A,
    8'h18, 8'h19, 8'h1A, 8'h1A, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h0A, 8'h17, 8'h1B,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h05, 8'h06, 8'h07,
    8'h1A, 8'h1A, 8'h16, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h04,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h14, 8'h15, 8'h1A, 8'h1A,
    8'h20, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h5B, 8'h2E, 8'h3C, 8'h28, 8'h2B, 8'h21,
    8'h26, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h5D, 8'h24, 8'h2A, 8'h29, 8'h3B, 8'h5E,
    8'h2D, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h7C, 8'h2C, 8'h25, 8'h5F, 8'h3E, 8'h3F,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h60, 8'h3A, 8'h23, 8'h40, 8'h27, 8'h3D, 8'h22,
    8'h1A, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
    8'h71, 8'h72, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h7E, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h7B, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h7D, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
    8'h51, 8'h52, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h5C, 8'h1A, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A, 8'h1A
  };

  typedef enum {ST_AWAIT, ST_HEADER, ST_PAYLOAD, ST_HALTED} deframe_state_t;
  typedef enum {NM_SPACES, NM_SOLID, NM_FIRST, NM_LASTCH, NM_TRAIL, NM_MIXED} name_mode_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] bsize;
    logic [31:0] offset;
    logic        last;
  } deframed_t;

  typedef struct {
    name_mode_t  coll_mode;
    name_mode_t  obj_mode;
    logic [31:0] blk_size;
    int          coll_chars;
    int          obj_chars;
  } record_row_t;

  typedef logic [7:0] name_bytes_t [NAME_LEN];

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  trd_in_if  in_ch ();
  trd_out_if out_ch ();

  tape_record_deframer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  deframe_state_t   dstate = ST_AWAIT;
  logic [31:0]      stream_len_reg = '0;
  logic [31:0]      stream_pos = '0;
  logic [31:0]      rec_offset = '0;
  logic [31:0]      size_acc = '0;
  logic [31:0]      payload_left = '0;
  logic [7:0]       name_buf [NAME_LEN];
  int               hdr_idx = 0;
  int               last_kept = 0;
  bit               tag_match = 1'b1;

  deframed_t        awaited_outputs [$];
  int               errors = 0;
  int               cycle_count = 0;
  int               bytes_taken = 0;
  int               good_records = 0;
  int               name_chars = 0;
  int               payload_bytes = 0;
  int               sync_errors = 0;
  int               coll_run_len = 0;
  int               obj_run_len = 0;
  bit               idling = 1'b0;
  int               stall_left = 0;

  record_row_t directed_rows [5] = '{
    '{NM_SPACES, NM_SPACES, 32'd0,     1,  1},
    '{NM_SOLID,  NM_FIRST,  32'd1,     44, 1},
    '{NM_LASTCH, NM_TRAIL,  32'h102,   44, 0},
    '{NM_MIXED,  NM_MIXED,  32'd3,     0,  0},
    '{NM_FIRST,  NM_SOLID,  32'd2,     1,  44}
  };

  function automatic void expect_result(kind_t k, logic [7:0] d, logic [31:0] s, logic l);
    awaited_outputs.push_back('{k, d, s, rec_offset, l});
  endfunction

  function automatic void deframe_header_byte(logic [7:0] b);
    int k;
    logic [7:0] c;
    kind_t run_kind;
    if (hdr_idx == 0) begin
      size_acc = '0;
      tag_match = 1'b1;
    end
    if (hdr_idx < 2 * NAME_LEN) begin
      k = (hdr_idx < NAME_LEN) ? hdr_idx : hdr_idx - NAME_LEN;
      c = ASCII_OF_EBCDIC[b];
      name_buf[k] = c;
      if (k == 0 || c != BLANK) last_kept = k;
      if (k == NAME_LEN - 1) begin
        run_kind = (hdr_idx < NAME_LEN) ? KIND_COLL : KIND_OBJ;
        for (int i = 0; i <= last_kept; i++) begin
          expect_result(run_kind, name_buf[i], '0, i == last_kept);
        end
        name_chars += last_kept + 1;
        if (run_kind == KIND_COLL) coll_run_len = last_kept + 1;
        else obj_run_len = last_kept + 1;
      end
    end else if (hdr_idx >= SIZE_AT && hdr_idx < SIZE_AT + 4) begin
      size_acc = {size_acc[23:0], b};
    end else if (hdr_idx >= TAG_AT && hdr_idx < TAG_AT + 4) begin
      if (b != SYNC_TAG[hdr_idx - TAG_AT]) tag_match = 1'b0;
      if (hdr_idx == TAG_AT + 3) begin
        if (!tag_match) begin
          expect_result(KIND_SYNC, '0, size_acc, 1'b0);
          dstate = ST_HALTED;
          sync_errors++;
          return;
        end
        expect_result(KIND_START, '0, size_acc, 1'b0);
        good_records++;
      end
    end
    hdr_idx++;
    if (hdr_idx >= HDR_LEN) begin
      hdr_idx = 0;
      payload_left = size_acc;
      dstate = (size_acc != 0) ? ST_PAYLOAD : ST_AWAIT;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [31:0] pos;
    pos = stream_pos;
    stream_pos = pos + 1;
    case (dstate)
      ST_AWAIT: begin
        if ({32'd0, stream_len_reg} > {32'd0, pos} + 64'd128) begin
          rec_offset = pos;
          hdr_idx = 0;
          dstate = ST_HEADER;
          deframe_header_byte(b);
        end
      end
      ST_HEADER: begin
        deframe_header_byte(b);
      end
      ST_PAYLOAD: begin
        expect_result(KIND_PAYLOAD, b, '0, 1'b0);
        payload_bytes++;
        payload_left--;
        if (payload_left == 0) dstate = ST_AWAIT;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    deframed_t want;
    cycle_count++;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.tape_byte);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_outputs.size() == 0) begin
          $error("unexpected result: kind %0d data 0x%0h", out_ch.kind, out_ch.data_byte);
          errors++;
        end else begin
          want = awaited_outputs.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("data_byte", 32'(want.data), 32'(out_ch.data_byte));
          check_field("block_size", want.bsize, out_ch.block_size);
          check_field("header_offset", want.offset, out_ch.header_offset);
          check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, awaited_outputs.size());
    $display("** tape_record_deframer: FAILED **");
    $finish;
  end

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_stream_length(input logic [31:0] v);
    logic [31:0] rd;
    apb_write(ADDR_STREAM_LENGTH, v);
    apb_read(ADDR_STREAM_LENGTH, rd);
    check_field("stream_length readback", v, rd);
    stream_len_reg = v;
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.tape_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained(input bit settle);
    while (awaited_outputs.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_nonblank();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == EBCDIC_BLANK);
    return v;
  endfunction

  function automatic name_bytes_t make_name(name_mode_t m);
    name_bytes_t nm;
    int n;
    n = $urandom_range(1, NAME_LEN - 1);
    for (int i = 0; i < NAME_LEN; i++) begin
      case (m)
        NM_SPACES: nm[i] = EBCDIC_BLANK;
        NM_SOLID:  nm[i] = pick_nonblank();
        NM_FIRST:  nm[i] = (i == 0) ? pick_nonblank() : EBCDIC_BLANK;
        NM_LASTCH: nm[i] = (i == NAME_LEN - 1) ? pick_nonblank() : EBCDIC_BLANK;
        NM_TRAIL: begin
          if (i < n - 1) nm[i] = 8'($urandom_range(0, 255));
          else if (i == n - 1) nm[i] = pick_nonblank();
          else nm[i] = EBCDIC_BLANK;
        end
        default: nm[i] = ($urandom_range(0, 3) == 0) ? EBCDIC_BLANK :
                         8'($urandom_range(0, 255));
      endcase
    end
    return nm;
  endfunction

  task automatic send_record(input name_mode_t cm, input name_mode_t om,
                             input logic [31:0] bsize, input int payload_n,
                             input bit tag_good, input bit pause_mid);
    logic [7:0] hdr [HDR_LEN];
    name_bytes_t cn;
    name_bytes_t on;
    int j;
    cn = make_name(cm);
    on = make_name(om);
    for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < NAME_LEN; i++) begin
      hdr[i] = cn[i];
      hdr[NAME_LEN + i] = on[i];
    end
    for (int i = 0; i < 4; i++) begin
      hdr[SIZE_AT + i] = bsize[31 - 8*i -: 8];
      hdr[TAG_AT + i] = SYNC_TAG[i];
    end
    if (!tag_good) begin
      j = $urandom_range(0, 3);
      hdr[TAG_AT + j] = hdr[TAG_AT + j] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < HDR_LEN; i++) begin
      send_byte(hdr[i]);
      if (pause_mid && i == NAME_LEN - 1) begin
        stop_sending();
        wait_drained(1'b0);
      end
    end
    for (int i = 0; i < payload_n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [31:0] rd;
    int start_bytes;
    int rec_no;
    logic [31:0] bsize;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.tape_byte = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    apb_read(ADDR_STREAM_LENGTH, rd);
    check_field("stream_length after reset", 32'd0, rd);

    // zero length: every byte is dropped
    idling = 1'b1;
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    stop_sending();
    wait_drained(1'b1);

    set_stream_length(32'hFFFF_FFFF);
    foreach (directed_rows[r]) begin
      send_record(directed_rows[r].coll_mode, directed_rows[r].obj_mode,
                  directed_rows[r].blk_size, directed_rows[r].blk_size, 1'b1, 1'b0);
      if (directed_rows[r].coll_chars != 0 && coll_run_len != directed_rows[r].coll_chars) begin
        $error("row %0d collection run: expected %0d chars, predicted %0d",
               r, directed_rows[r].coll_chars, coll_run_len);
        errors++;
      end
      if (directed_rows[r].obj_chars != 0 && obj_run_len != directed_rows[r].obj_chars) begin
        $error("row %0d object run: expected %0d chars, predicted %0d",
               r, directed_rows[r].obj_chars, obj_run_len);
        errors++;
      end
    end

    start_bytes = bytes_taken;
    rec_no = 0;
    while (bytes_taken - start_bytes < RANDOM_BYTES) begin
      idling = ($urandom_range(0, 3) != 0);
      bsize = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
      send_record(name_mode_t'($urandom_range(0, 5)), name_mode_t'($urandom_range(0, 5)),
                  bsize, bsize, 1'b1, rec_no == 1);
      rec_no++;
    end
    stop_sending();
    wait_drained(1'b1);

    // header just fits, payload runs past the end, then the rest is dropped
    idling = 1'b0;
    set_stream_length(stream_pos + 32'd129);
    send_record(NM_TRAIL, NM_MIXED, 32'd10, 10, 1'b1, 1'b0);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    stop_sending();
    wait_drained(1'b1);

    // exactly a header's worth left: no start
    set_stream_length(stream_pos + 32'd128);
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    stop_sending();
    wait_drained(1'b1);

    // bad tag halts the block; later bytes give nothing
    set_stream_length(stream_pos + 32'd129 + 32'($urandom_range(0, 4000)));
    send_record(NM_MIXED, NM_SOLID, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    stop_sending();
    wait_drained(1'b1);

    $display("run took %0d tape bytes: %0d good records, %0d name chars, %0d payload bytes",
             bytes_taken, good_records, name_chars, payload_bytes);
    $display("stream lengths zero, all ones, tight fit and one short; %0d sync halt(s)",
             sync_errors);
    if (errors == 0) begin
      $display("** tape_record_deframer: PASSED **");
    end else begin
      $display("** tape_record_deframer: FAILED **");
    end
    $finish;
  end

endmodule
